// ----- src/scc_pkg.sv -----
// ----------------------------------------------------------------------------
// scc_pkg - sensor frame CRC check package
// Transaction types, frame layout constants and the CRC byte update.
// ----------------------------------------------------------------------------
package scc_pkg;

    // Frame layout
    localparam int unsigned FRAME_BYTES = 8;
    localparam int unsigned POS_W       = $clog2(FRAME_BYTES);

    localparam logic [POS_W-1:0] POS_FIRST    = POS_W'(0);
    localparam logic [POS_W-1:0] POS_HUM_HI   = POS_W'(2);
    localparam logic [POS_W-1:0] POS_HUM_LO   = POS_W'(3);
    localparam logic [POS_W-1:0] POS_TMP_HI   = POS_W'(4);
    localparam logic [POS_W-1:0] POS_TMP_LO   = POS_W'(5);
    localparam logic [POS_W-1:0] POS_CRC_LO   = POS_W'(FRAME_BYTES - 2);
    localparam logic [POS_W-1:0] POS_CRC_HI   = POS_W'(FRAME_BYTES - 1);

    // CRC-16, reflected form
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // Divide a 16-bit word by 10: (x * 52429) >> 19 is exact over 0..65535
    localparam logic [16:0] DIV10_MUL   = 17'd52429;
    localparam int unsigned DIV10_SHIFT = 19;
    localparam int unsigned VAL_W       = 13;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_start;
        logic       transfer_error;
    } t_scc_in;

    typedef struct packed {
        logic             frame_good;
        logic             crc_match;
        logic             transfer_failed;
        logic [VAL_W-1:0] humidity;
        logic [VAL_W-1:0] temperature;
    } t_scc_out;

    // Fold one byte into the CRC, one bit per step
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// ----- src/sensor_frame_crc_check_top.sv -----
// ----------------------------------------------------------------------------
// sensor_frame_crc_check_top - sensor reply frame checker
// Runs CRC-16 over a byte stream frame and decodes humidity and temperature.
// ----------------------------------------------------------------------------
// Takes one frame byte per cycle, back to back, unless stalled, and emits one
// result transaction on the last byte of each eight-byte frame, in the cycle
// after that byte is taken. The CRC byte update is done combinationally at the
// input; each divide by 10 is a constant multiply done as its low byte arrives,
// so the final byte only needs a compare. A byte with frame_start set begins a
// new frame and drops any partial one. Input is stalled only while a result
// sits in the output register and the downstream side stalls.
module sensor_frame_crc_check_top (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  scc_pkg::t_scc_in  i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output scc_pkg::t_scc_out o_out_data
);
    import scc_pkg::*;

    logic [15:0]      r_crc, n_crc;
    logic [POS_W-1:0] r_pos, n_pos;
    logic             r_err, n_err;
    logic [7:0]       r_word_hi, n_word_hi;
    logic [7:0]       r_crc_lo, n_crc_lo;
    logic [VAL_W-1:0] r_hum_q, n_hum_q;
    logic [VAL_W-1:0] r_tmp_q, n_tmp_q;
    logic             r_out_valid, n_out_valid;
    t_scc_out         r_out, n_out;

    logic             in_take;
    logic             out_free;
    logic [POS_W-1:0] pos;
    logic [15:0]      crc_base;
    logic             err_base;
    logic             err_now;
    logic [15:0]      crc_upd;
    logic [15:0]      div_word;
    logic [31:0]      div_prod;
    logic [VAL_W-1:0] div_q;
    logic             match;

    // Hold input while the result register is full and stalled
    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = !out_free;
    assign in_take    = i_in_valid && out_free;

    // Restart frame state on a start mark
    assign pos      = i_in_data.frame_start ? POS_FIRST : r_pos;
    assign crc_base = i_in_data.frame_start ? CRC_INIT : r_crc;
    assign err_base = i_in_data.frame_start ? 1'b0 : r_err;
    assign err_now  = err_base | i_in_data.transfer_error;
    assign crc_upd  = crc_byte(crc_base, i_in_data.data_byte);

    // Shared divide by 10 for the word completed by this byte
    assign div_word = {r_word_hi, i_in_data.data_byte};
    assign div_prod = {16'd0, div_word} * {15'd0, DIV10_MUL};
    assign div_q    = div_prod[DIV10_SHIFT +: VAL_W];

    // Compare received CRC, low byte first
    assign match = (r_crc_lo == crc_base[7:0]) && (i_in_data.data_byte == crc_base[15:8]);

    // Next-state logic
    always_comb begin
        n_crc       = r_crc;
        n_pos       = r_pos;
        n_err       = r_err;
        n_word_hi   = r_word_hi;
        n_crc_lo    = r_crc_lo;
        n_hum_q     = r_hum_q;
        n_tmp_q     = r_tmp_q;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;

        if (in_take) begin
            n_err = err_now;
            n_pos = pos + POS_W'(1);
            if (pos < POS_CRC_LO) begin
                n_crc = crc_upd;
            end else begin
                n_crc = crc_base;
            end

            unique case (pos)
                POS_HUM_HI, POS_TMP_HI: begin
                    n_word_hi = i_in_data.data_byte;
                end
                POS_HUM_LO: begin
                    n_hum_q = div_q;
                end
                POS_TMP_LO: begin
                    n_tmp_q = div_q;
                end
                POS_CRC_LO: begin
                    n_crc_lo = i_in_data.data_byte;
                end
                POS_CRC_HI: begin
                    n_out.frame_good      = match && !err_now;
                    n_out.crc_match       = match;
                    n_out.transfer_failed = err_now;
                    n_out.humidity        = r_hum_q;
                    n_out.temperature     = r_tmp_q;
                    n_out_valid           = 1'b1;
                    n_crc                 = CRC_INIT;
                    n_err                 = 1'b0;
                    n_pos                 = POS_FIRST;
                end
                default: begin
                end
            endcase
        end
    end

    // Hold state and the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc       <= CRC_INIT;
            r_pos       <= POS_FIRST;
            r_err       <= 1'b0;
            r_word_hi   <= 8'd0;
            r_crc_lo    <= 8'd0;
            r_hum_q     <= '0;
            r_tmp_q     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_crc       <= n_crc;
            r_pos       <= n_pos;
            r_err       <= n_err;
            r_word_hi   <= n_word_hi;
            r_crc_lo    <= n_crc_lo;
            r_hum_q     <= n_hum_q;
            r_tmp_q     <= n_tmp_q;
            r_out_valid <= n_out_valid;
        end
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
